// ===== rtl/md5_pkg.sv =====
// Package for the MD5 digest block: initial vector, round constants,
// rotation amounts and the state encoding. No dependencies.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_LEN   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       end_only;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

endpackage

// ===== rtl/md5_stream_if.sv =====
// Valid/ready channel interface carrying one MD5 input or output item.
// The payload type is a parameter (md5_pkg types in use); the interface itself does not import md5_pkg.
interface md5_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/md5_message_digest.sv =====
// MD5 digest top level: byte gathering, padding, one shared round unit.
// Depends on md5_pkg and md5_stream_if.
// Each byte is stored; one that completes a block then runs the 64 rounds and
// the add step. Message end: padding from the pad position to byte 63 (all of
// a second block), the length step on the final block, then 64 rounds and
// the add step per padded block (one or two), then four output transfers.
// Reset is asynchronous and restores the initial vector.
module md5_message_digest (
    input  logic         clk,
    input  logic         rst_n,
    md5_stream_if.sink   in_ch,
    md5_stream_if.source out_ch
);
    import md5_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] buf_reg [16];
    logic [31:0] cv_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] count_reg;
    logic [5:0]  round_reg;
    logic [5:0]  pos_reg;
    logic        final_reg;
    logic        len_done_reg;
    logic [1:0]  out_idx_reg;

    logic [1:0]  pass;
    logic [31:0] f_val, sum, rot;
    logic [3:0]  g_idx;
    logic [4:0]  sh;

    always_comb
    begin
        pass = round_reg[5:4];
        unique case (pass)
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = round_reg[3:0];
            end
            2'd1:
            begin
                f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
                g_idx = 4'(5 * round_reg + 1);
            end
            2'd2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'(3 * round_reg + 5);
            end
            default:
            begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'(7 * round_reg);
            end
        endcase
        sum = a_reg + f_val + ROUND_K[round_reg] + buf_reg[g_idx];
        sh  = ROT_S[{pass, round_reg[1:0]}];
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.payload.digest_word = cv_reg[out_idx_reg];
    assign out_ch.payload.word_index  = out_idx_reg;
    assign out_ch.payload.last_word   = (out_idx_reg == 2'd3);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid && !in_ch.payload.end_only)
        begin
            buf_reg[count_reg[5:2]][count_reg[1:0]*8 +: 8] <= in_ch.payload.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            buf_reg[pos_reg[5:2]][pos_reg[1:0]*8 +: 8] <=
                (pos_reg == count_reg[5:0]) ? PAD_BYTE : 8'h00;
        end
        else if (state_reg == ST_LEN)
        begin
            buf_reg[14] <= {count_reg[28:0], 3'b000};
            buf_reg[15] <= count_reg[60:29];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cv_reg       <= '{IV_A, IV_B, IV_C, IV_D};
            count_reg    <= '0;
            round_reg    <= '0;
            pos_reg      <= '0;
            final_reg    <= 1'b0;
            len_done_reg <= 1'b0;
            out_idx_reg  <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    round_reg <= '0;
                    a_reg <= cv_reg[0]; b_reg <= cv_reg[1];
                    c_reg <= cv_reg[2]; d_reg <= cv_reg[3];
                    if (in_ch.valid)
                    begin
                        if (in_ch.payload.end_only)
                        begin
                            final_reg <= 1'b1;
                            pos_reg   <= count_reg[5:0];
                        end
                        else
                        begin
                            count_reg <= count_reg + 64'd1;
                            final_reg <= in_ch.payload.last_byte;
                            pos_reg   <= 6'(count_reg[5:0] + 6'd1);
                        end
                        len_done_reg <= 1'b0;
                    end
                end
                ST_PAD:
                begin
                    pos_reg <= 6'(pos_reg + 6'd1);
                end
                ST_LEN:
                begin
                    len_done_reg <= 1'b1;
                    round_reg <= '0;
                    a_reg <= cv_reg[0]; b_reg <= cv_reg[1];
                    c_reg <= cv_reg[2]; d_reg <= cv_reg[3];
                end
                ST_ROUND:
                begin
                    a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg;
                    b_reg <= b_reg + rot;
                    round_reg <= 6'(round_reg + 6'd1);
                end
                ST_ADD:
                begin
                    cv_reg[0] <= cv_reg[0] + a_reg;
                    cv_reg[1] <= cv_reg[1] + b_reg;
                    cv_reg[2] <= cv_reg[2] + c_reg;
                    cv_reg[3] <= cv_reg[3] + d_reg;
                    round_reg <= '0;
                    a_reg <= cv_reg[0] + a_reg; b_reg <= cv_reg[1] + b_reg;
                    c_reg <= cv_reg[2] + c_reg; d_reg <= cv_reg[3] + d_reg;
                    pos_reg <= '0;
                end
                ST_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        out_idx_reg <= 2'(out_idx_reg + 2'd1);
                        if (out_idx_reg == 2'd3)
                        begin
                            cv_reg    <= '{IV_A, IV_B, IV_C, IV_D};
                            count_reg <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Padding fills from pos to the block end; when the pad byte lands at
    // or past byte 56 the block is compressed before the length is written.
    // After that first block, pos restarts at zero and the whole next block
    // is cleared (pad byte only where pos equals the message position).
    logic pad_first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_first_reg <= 1'b1;
        end
        else if (state_reg == ST_IDLE)
        begin
            pad_first_reg <= 1'b1;
        end
        else if (state_reg == ST_ADD)
        begin
            pad_first_reg <= 1'b0;
        end
    end

    logic pad_second;
    assign pad_second = count_reg[5:0] >= 6'd56;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.payload.end_only)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (count_reg[5:0] == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (in_ch.payload.last_byte)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pos_reg == 6'd63)
                begin
                    state_next = (pad_first_reg && pad_second) ? ST_ROUND : ST_LEN;
                end
            end
            ST_LEN:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_done_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready && out_idx_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
